FILE: rtl/core/baic_pkg.sv
// Shared types, codes and arithmetic helpers for the bilinear compositor.
package baic_pkg;

  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 32;
  localparam int TEXEL_AW   = 16;
  localparam int TEXEL_DEPTH = 65536;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_DRAW  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [2:0] MODE_COPY_MASK = 3'd0;
  localparam logic [2:0] MODE_COPY_ARGB = 3'd1;
  localparam logic [2:0] MODE_MASK_OVER = 3'd2;
  localparam logic [2:0] MODE_ARGB_OVER = 3'd3;
  localparam logic [2:0] MODE_TINT      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_U_COL = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_V_COL = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_U_ROW = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_V_ROW = 4'd7;

  // load: d0 = texel; start: d0 = u, d1 = v; draw: d0 = dst, d1 = color
  typedef struct packed {
    action_t     kind;
    logic [15:0] idx;
    logic [31:0] d0;
    logic [31:0] d1;
  } cmd_t;

  // a + floor((b - a) * t / 65536)
  function automatic logic [7:0] lerp16(input logic [7:0] a, input logic [7:0] b,
                                        input logic [15:0] t);
    logic signed [8:0]  d;
    logic signed [25:0] p;
    logic signed [9:0]  r;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, t});
    r = $signed({2'b00, a}) + 10'(p >>> 16);
    return r[7:0];
  endfunction

  // rounded x*y/255 with flooring shifts
  function automatic logic signed [9:0] mul255(input logic signed [9:0] x,
                                               input logic [7:0] y);
    logic signed [19:0] p;
    logic signed [19:0] q;
    p = x * $signed({2'b00, y}) + 20'sd128;
    q = p + (p >>> 8);
    return 10'(q >>> 8);
  endfunction

  function automatic logic [7:0] over_lane(input logic [7:0] s, input logic [7:0] d,
                                           input logic [7:0] inv);
    logic signed [9:0] m;
    m = mul255($signed({2'b00, d}), inv);
    return 8'(s + m[7:0]);
  endfunction

  function automatic logic [7:0] tint_lane(input logic [7:0] c, input logic [7:0] d,
                                           input logic [7:0] ca);
    logic signed [9:0] m;
    m = mul255($signed({2'b00, c}) - $signed({2'b00, d}), ca);
    return 8'(d + m[7:0]);
  endfunction

endpackage

FILE: rtl/core/baic_ram.sv
// Generic single-write, single-read RAM with registered read data.
module baic_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/baic_front.sv
// Input side: decodes the action and queues commands for the back end.
module baic_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [baic_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                      in_tuser,
  output logic                            q_valid,
  output baic_pkg::cmd_t                  q_cmd,
  input  logic                            q_pop
);
  import baic_pkg::*;

  cmd_t       ent_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;
  cmd_t       cmd;
  logic       push;

  always_comb begin
    cmd.kind = action_t'(in_tuser);
    cmd.idx  = in_tdata[15:0];
    cmd.d0   = '0;
    cmd.d1   = '0;
    unique case (action_t'(in_tuser))
      ACT_LOAD:  cmd.d0 = in_tdata[47:16];
      ACT_START: begin
        cmd.d0 = in_tdata[79:48];
        cmd.d1 = in_tdata[111:80];
      end
      ACT_DRAW:  begin
        cmd.d0 = in_tdata[143:112];
        cmd.d1 = in_tdata[175:144];
      end
      ACT_NONE:  cmd.d0 = '0;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  // unused action code is consumed and dropped here
  assign push      = in_tvalid && in_tready && (action_t'(in_tuser) != ACT_NONE);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_cmd     = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        ent_r[wr_r] <= cmd;
        wr_r        <= ~wr_r;
      end
      if (q_pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, q_pop});
    end
  end

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("queue popped while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> cnt_r == 2'($past(cnt_r) + 2'd1))
    else $error("queue count did not follow push");

endmodule

FILE: rtl/core/baic_back.sv
// Back end: configuration, texel store, bilinear filter, blend and affine walk.
module baic_back #(
  parameter int MAX_SRC_W = 256,
  parameter int MAX_SRC_H = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [baic_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [baic_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             q_valid,
  input  baic_pkg::cmd_t                   q_cmd,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [baic_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);
  import baic_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLAMP, S_ADDR, S_FETCH, S_LERPU, S_LERPV, S_BLEND1, S_BLEND2, S_DONE
  } state_t;

  state_t       state_r;
  logic [2:0]   mode_r;
  logic [8:0]   srcw_r, srch_r;
  logic [15:0]  roww_r;
  logic [31:0]  suc_r, svc_r, sur_r, svr_r;
  logic [31:0]  row_u_r, row_v_r, cur_u_r, cur_v_r;
  logic [15:0]  colcnt_r;
  logic [31:0]  dst_r, col_r;
  logic [8:0]   w_r, x0_r, x1_r, y0_r, y1_r;
  logic [17:0]  rowa0_r, rowa1_r;
  logic [2:0]   cnt_r;
  logic [31:0]  q_r [4];
  logic [7:0]   ab_r [4];
  logic [7:0]   cd_r [4];
  logic [7:0]   s_r [4];
  logic [7:0]   ca_r;
  logic [31:0]  res_r;
  logic         out_valid_r;
  logic [31:0]  out_data_r;
  logic         out_last_r;

  logic [8:0]   w_eff, h_eff;
  logic signed [16:0] xi, yi;
  logic [15:0]  raddr;
  logic [31:0]  rdata;
  logic         ram_we;
  logic [15:0]  col_nx;
  logic         wrap;
  logic         out_free;
  logic [31:0]  blend1;
  logic [31:0]  blend2;
  logic [7:0]   ca;

  function automatic logic [8:0] clamp(input logic signed [16:0] c, input logic [8:0] lim);
    logic [8:0] r;
    if (c < 0) begin
      r = '0;
    end else if (c >= $signed({8'b0, lim})) begin
      r = 9'(lim - 9'd1);
    end else begin
      r = c[8:0];
    end
    return r;
  endfunction

  always_comb begin
    w_eff = (srcw_r == 9'd0) ? 9'd1 : srcw_r;
    h_eff = (srch_r == 9'd0) ? 9'd1 : srch_r;
    if (32'(w_eff) > MAX_SRC_W) begin
      w_eff = 9'(MAX_SRC_W);
    end
    if (32'(h_eff) > MAX_SRC_H) begin
      h_eff = 9'(MAX_SRC_H);
    end
  end

  assign xi = $signed({cur_u_r[31], cur_u_r[31:16]});
  assign yi = $signed({cur_v_r[31], cur_v_r[31:16]});

  always_comb begin
    unique case (cnt_r[1:0])
      2'd0: raddr = 16'(rowa0_r + 18'(x0_r));
      2'd1: raddr = 16'(rowa0_r + 18'(x1_r));
      2'd2: raddr = 16'(rowa1_r + 18'(x0_r));
      2'd3: raddr = 16'(rowa1_r + 18'(x1_r));
    endcase
  end

  assign q_pop  = (state_r == S_IDLE) && q_valid;
  assign ram_we = q_pop && (q_cmd.kind == ACT_LOAD);

  baic_ram #(.W(32), .DEPTH(TEXEL_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_cmd.idx),
    .wdata (q_cmd.d0),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    unique case (mode_r)
      MODE_COPY_MASK: blend1 = {24'b0, s_r[3]};
      MODE_COPY_ARGB: blend1 = {s_r[0], s_r[1], s_r[2], s_r[3]};
      MODE_MASK_OVER: blend1 = {24'b0, over_lane(s_r[3], dst_r[7:0], 8'(8'd255 - s_r[3]))};
      MODE_ARGB_OVER: blend1 = {over_lane(s_r[0], dst_r[31:24], 8'(8'd255 - s_r[0])),
                                over_lane(s_r[1], dst_r[23:16], 8'(8'd255 - s_r[0])),
                                over_lane(s_r[2], dst_r[15:8],  8'(8'd255 - s_r[0])),
                                over_lane(s_r[3], dst_r[7:0],   8'(8'd255 - s_r[0]))};
      default:        blend1 = dst_r;
    endcase
  end

  assign ca     = 8'(mul255($signed({2'b00, s_r[3]}), col_r[31:24]));
  assign blend2 = {over_lane(ca_r, dst_r[31:24], 8'(8'd255 - ca_r)),
                   tint_lane(col_r[23:16], dst_r[23:16], ca_r),
                   tint_lane(col_r[15:8],  dst_r[15:8],  ca_r),
                   tint_lane(col_r[7:0],   dst_r[7:0],   ca_r)};

  // zero column count after wrap means 65536 pixels: that also ends the row
  assign col_nx   = 16'(colcnt_r + 16'd1);
  assign wrap     = (col_nx >= roww_r) || (col_nx == 16'd0);
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_COPY_MASK;
      srcw_r      <= 9'd1;
      srch_r      <= 9'd1;
      roww_r      <= 16'd1;
      suc_r       <= 32'h0001_0000;
      svc_r       <= '0;
      sur_r       <= '0;
      svr_r       <= 32'h0001_0000;
      row_u_r     <= '0;
      row_v_r     <= '0;
      cur_u_r     <= '0;
      cur_v_r     <= '0;
      colcnt_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:       mode_r <= cfg_wdata[2:0];
          CFG_SRC_WIDTH:  srcw_r <= cfg_wdata[8:0];
          CFG_SRC_HEIGHT: srch_r <= cfg_wdata[8:0];
          CFG_ROW_WIDTH:  roww_r <= cfg_wdata[15:0];
          CFG_STEP_U_COL: suc_r  <= cfg_wdata;
          CFG_STEP_V_COL: svc_r  <= cfg_wdata;
          CFG_STEP_U_ROW: sur_r  <= cfg_wdata;
          CFG_STEP_V_ROW: svr_r  <= cfg_wdata;
          default: ;
        endcase
      end
      // a finishing draw reloads the output register in S_DONE instead
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_cmd.kind == ACT_START) begin
              row_u_r  <= q_cmd.d0;
              cur_u_r  <= q_cmd.d0;
              row_v_r  <= q_cmd.d1;
              cur_v_r  <= q_cmd.d1;
              colcnt_r <= '0;
            end else if (q_cmd.kind == ACT_DRAW) begin
              dst_r   <= q_cmd.d0;
              col_r   <= q_cmd.d1;
              state_r <= S_CLAMP;
            end
          end
        end
        S_CLAMP: begin
          w_r     <= w_eff;
          x0_r    <= clamp(xi, w_eff);
          x1_r    <= clamp(17'(xi + 17'sd1), w_eff);
          y0_r    <= clamp(yi, h_eff);
          y1_r    <= clamp(17'(yi + 17'sd1), h_eff);
          state_r <= S_ADDR;
        end
        S_ADDR: begin
          rowa0_r <= y0_r * w_r;
          rowa1_r <= y1_r * w_r;
          cnt_r   <= '0;
          state_r <= S_FETCH;
        end
        S_FETCH: begin
          // read data is registered, so each word belongs to the address of the step before
          if (cnt_r != 3'd0) begin
            q_r[2'(cnt_r - 3'd1)] <= rdata;
          end
          cnt_r <= 3'(cnt_r + 3'd1);
          if (cnt_r == 3'd4) begin
            state_r <= S_LERPU;
          end
        end
        S_LERPU: begin
          for (int k = 0; k < 4; k++) begin
            ab_r[k] <= lerp16(q_r[0][24-8*k +: 8], q_r[1][24-8*k +: 8], cur_u_r[15:0]);
            cd_r[k] <= lerp16(q_r[2][24-8*k +: 8], q_r[3][24-8*k +: 8], cur_u_r[15:0]);
          end
          state_r <= S_LERPV;
        end
        S_LERPV: begin
          for (int k = 0; k < 4; k++) begin
            s_r[k] <= lerp16(ab_r[k], cd_r[k], cur_v_r[15:0]);
          end
          state_r <= S_BLEND1;
        end
        S_BLEND1: begin
          ca_r    <= ca;
          res_r   <= blend1;
          state_r <= (mode_r == MODE_TINT) ? S_BLEND2 : S_DONE;
        end
        S_BLEND2: begin
          res_r   <= blend2;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res_r;
            out_last_r  <= wrap;
            if (wrap) begin
              colcnt_r <= '0;
              row_u_r  <= row_u_r + sur_r;
              row_v_r  <= row_v_r + svr_r;
              cur_u_r  <= row_u_r + sur_r;
              cur_v_r  <= row_v_r + svr_r;
            end else begin
              colcnt_r <= col_nx;
              cur_u_r  <= cur_u_r + suc_r;
              cur_v_r  <= cur_v_r + svc_r;
            end
            state_r <= S_IDLE;
          end else if (out_valid_r && out_tready) begin
            out_valid_r <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> out_valid_r)
    else $error("finished draw did not reach the output register");
  a_fetch_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FETCH |-> cnt_r <= 3'd4)
    else $error("fetch counter overran");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_cmd.kind == ACT_DRAW) |=> state_r == S_CLAMP)
    else $error("draw command not started");

endmodule

FILE: rtl/core/bilinear_affine_image_compositor_unit.sv
// Top level of the bilinear affine image compositor.
//
//  channel  dir  handshake         payload
//  in_      in   tvalid/tready     tdata: texel_index, texel_value, start_u, start_v,
//                                  dst_pixel, solid_color; tuser: action
//  out_     out  tvalid/tready     tdata: result_pixel; tlast: row_end
//  cfg_     in   we (no wait)      index, wdata
//
// A load or start item is handled at its pop in the back end. A draw runs through
// the pop, clamp and address stages, four texel reads from the single read port
// of the texel store, two lerp stages and the blend stages (a second blend stage
// for a color-through-mask blend). A full output register stalls the final stage.
// A two-entry command queue lets input transfers continue while the back end
// works or the output register waits. Reset is synchronous; the store is not cleared.
module bilinear_affine_image_compositor_unit #(
  parameter int MAX_SRC_W = 256,
  parameter int MAX_SRC_H = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // texel_index, texel_value, start_u, start_v, dst_pixel, solid_color
  input  logic [baic_pkg::IN_DATA_W-1:0]   in_tdata,
  // action
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // result_pixel
  output logic [baic_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [baic_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [baic_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import baic_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  baic_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  baic_back #(.MAX_SRC_W(MAX_SRC_W), .MAX_SRC_H(MAX_SRC_H)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
